// ===== rtl/ipm_pkg.sv =====
// Shared constants and types for the integer polynomial multiplier.
package ipm_pkg;

  localparam int MAX_TERMS = 32;
  localparam int COEF_BITS = 21;
  localparam int IN_COEF_W = 21;
  localparam int CMD_W     = 2;
  localparam int RIDX_W    = 6;
  localparam int VAL_W     = 48;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int PROD_W    = 2 * COEF_BITS;
  localparam int EXT_W     = (PROD_W > VAL_W) ? PROD_W : VAL_W;

  localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE  = 2'd2;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [VAL_W-1:0]     val_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ERR
  } ipm_state_t;

  typedef struct packed {
    logic adv;
    logic clr;
  } ipm_ctl_t;

endpackage

// ===== rtl/ipm_cell.sv =====
// One tap of the transposed convolution chain: holds A[k], multiplies, accumulates.
module ipm_cell
  import ipm_pkg::*;
(
  input  logic     clk,
  input  ipm_ctl_t ctl,
  input  logic     load,
  input  coef_t    load_data,
  input  logic     active,
  input  coef_t    x,
  input  val_t     p_in,
  output val_t     p_out
);

  coef_t a_r;
  val_t  prod_r;
  val_t  prod_nxt;
  val_t  p_r;
  val_t  p_nxt;

  logic signed [PROD_W-1:0] mul;
  logic signed [EXT_W-1:0]  mul_ext;

  assign mul      = a_r * x;
  assign mul_ext  = EXT_W'(mul);
  assign prod_nxt = active ? mul_ext[VAL_W-1:0] : '0;
  assign p_nxt    = prod_r + p_in;
  assign p_out    = p_r;

  always_ff @(posedge clk) begin
    if (load) begin
      a_r <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      prod_r <= '0;
      p_r    <= '0;
    end else if (ctl.adv) begin
      prod_r <= prod_nxt;
      p_r    <= p_nxt;
    end
  end

endmodule

// ===== rtl/integer_polynomial_multiply_top.sv =====
// Integer polynomial multiplier: list storage, sequencer and chain of MAC cells.
// Appends are taken whenever idle. A compute run streams B through the chain, one
// coefficient per cycle unless the output stalls (stalls freeze the chain), and emits
// n+m-1 results; the first passes x feed, product, partial sum and output registers, the
// rest one per cycle unless stalled. An error run registers its single result from ST_ERR.
// Synchronous active-low reset clears counts, overflow mark, sequencer and output valid.
module integer_polynomial_multiply_top
  import ipm_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [CMD_W-1:0]            in_command,
  input  logic signed [IN_COEF_W-1:0] in_coefficient,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [RIDX_W-1:0]           out_result_index,
  output logic signed [VAL_W-1:0]     out_product_value,
  output logic                        out_last_item,
  output logic                        out_error_flag
);

  ipm_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  first_count_r, first_count_nxt;
  logic [CNT_W-1:0]  second_count_r, second_count_nxt;
  logic              overflow_r, overflow_nxt;
  logic [CNT_W-1:0]  n_run_r, n_run_nxt;
  logic [CNT_W-1:0]  m_run_r, m_run_nxt;
  logic [RIDX_W-1:0] total_r, total_nxt;
  logic [RIDX_W-1:0] t_r, t_nxt;

  coef_t b_mem [MAX_TERMS];
  logic  b_we;
  logic  a_we;

  coef_t x_r;
  logic  x_take;
  logic  v0_r, v1_r, v2_r, v0_nxt;
  logic  last0_r, last1_r, last2_r, last0_nxt;
  logic [RIDX_W-1:0] idx0_r, idx1_r, idx2_r;

  logic              out_valid_r;
  logic [RIDX_W-1:0] out_idx_r;
  val_t              out_val_r;
  logic              out_last_r;
  logic              out_err_r;

  ipm_ctl_t ctl;
  logic     in_xfer;
  coef_t    coef_w;
  val_t     chain [MAX_TERMS+1];

  assign coef_w  = in_coefficient[COEF_BITS-1:0];
  assign in_xfer = in_valid && in_ready;

  always_comb begin
    state_nxt        = state_r;
    first_count_nxt  = first_count_r;
    second_count_nxt = second_count_r;
    overflow_nxt     = overflow_r;
    n_run_nxt        = n_run_r;
    m_run_nxt        = m_run_r;
    total_nxt        = total_r;
    t_nxt            = t_r;
    in_ready         = 1'b0;
    a_we             = 1'b0;
    b_we             = 1'b0;
    ctl.adv          = !out_valid_r || out_ready;
    ctl.clr          = 1'b0;
    v0_nxt           = 1'b0;
    last0_nxt        = 1'b0;
    x_take           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_xfer) begin
          unique case (in_command)
            CMD_APPEND_A: begin
              if (first_count_r >= CNT_W'(MAX_TERMS)) begin
                overflow_nxt = 1'b1;
              end else begin
                a_we            = 1'b1;
                first_count_nxt = first_count_r + 1'b1;
              end
            end
            CMD_APPEND_B: begin
              if (second_count_r >= CNT_W'(MAX_TERMS)) begin
                overflow_nxt = 1'b1;
              end else begin
                b_we             = 1'b1;
                second_count_nxt = second_count_r + 1'b1;
              end
            end
            CMD_COMPUTE: begin
              first_count_nxt  = '0;
              second_count_nxt = '0;
              overflow_nxt     = 1'b0;
              if (first_count_r == '0 || second_count_r == '0 || overflow_r) begin
                state_nxt = ST_ERR;
              end else begin
                state_nxt = ST_RUN;
                ctl.clr   = 1'b1;
                n_run_nxt = first_count_r;
                m_run_nxt = second_count_r;
                total_nxt = RIDX_W'(first_count_r) + RIDX_W'(second_count_r) - 1'b1;
                t_nxt     = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        v0_nxt    = 1'b1;
        last0_nxt = (t_r == total_r - 1'b1);
        x_take    = (RIDX_W'(m_run_r) > t_r);
        if (ctl.adv) begin
          t_nxt = t_r + 1'b1;
          if (last0_nxt) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!v0_r && !v1_r && !v2_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (ctl.adv) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      first_count_r  <= '0;
      second_count_r <= '0;
      overflow_r     <= 1'b0;
      n_run_r        <= '0;
      m_run_r        <= '0;
      total_r        <= '0;
      t_r            <= '0;
    end else begin
      state_r        <= state_nxt;
      first_count_r  <= first_count_nxt;
      second_count_r <= second_count_nxt;
      overflow_r     <= overflow_nxt;
      n_run_r        <= n_run_nxt;
      m_run_r        <= m_run_nxt;
      total_r        <= total_nxt;
      t_r            <= t_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[second_count_r[IDX_W-1:0]] <= coef_w;
    end
  end

  // stage tags: x feed, product, partial sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (ctl.adv) begin
      v0_r <= v0_nxt;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      idx0_r  <= t_r;
      idx1_r  <= idx0_r;
      idx2_r  <= idx1_r;
      last0_r <= last0_nxt;
      last1_r <= last0_r;
      last2_r <= last1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      x_r <= '0;
    end else if (ctl.adv) begin
      x_r <= x_take ? b_mem[t_r[IDX_W-1:0]] : '0;
    end
  end

  assign chain[MAX_TERMS] = '0;

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
    ipm_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load      (a_we && (first_count_r[IDX_W-1:0] == IDX_W'(k))),
      .load_data (coef_w),
      .active    (n_run_r > CNT_W'(k)),
      .x         (x_r),
      .p_in      (chain[k+1]),
      .p_out     (chain[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.adv) begin
      out_valid_r <= (state_r == ST_ERR) || v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      if (state_r == ST_ERR) begin
        out_idx_r  <= '0;
        out_val_r  <= '0;
        out_last_r <= 1'b1;
        out_err_r  <= 1'b1;
      end else begin
        out_idx_r  <= idx2_r;
        out_val_r  <= chain[0];
        out_last_r <= last2_r;
        out_err_r  <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_index  = out_idx_r;
  assign out_product_value = out_val_r;
  assign out_last_item     = out_last_r;
  assign out_error_flag    = out_err_r;

endmodule

// ===== test/tb_top.sv =====
// Testbench for integer_polynomial_multiply_top: checks every product coefficient.
`timescale 1ns / 100ps

module tb_top
  import ipm_pkg::*;
();

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam coef_t COEF_MAX = {1'b0, {(COEF_BITS - 1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_BITS - 1){1'b0}}};

  typedef struct {
    logic [RIDX_W-1:0] idx;
    val_t              value;
    logic              last;
    logic              err;
  } product_term_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [CMD_W-1:0]            in_command;
  logic signed [IN_COEF_W-1:0] in_coefficient;
  logic                        out_valid;
  logic                        out_ready;
  logic [RIDX_W-1:0]           out_result_index;
  logic signed [VAL_W-1:0]     out_product_value;
  logic                        out_last_item;
  logic                        out_error_flag;

  coef_t         terms_a [MAX_TERMS];
  coef_t         terms_b [MAX_TERMS];
  int            count_a = 0;
  int            count_b = 0;
  bit            list_overflow = 1'b0;
  product_term_t pending_terms[$];

  int fail_count = 0;
  int items_sent = 0;
  int sink_hold_cycles = 0;
  bit src_idle_en;
  bit sink_idle_en;

  integer_polynomial_multiply_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_coefficient   (in_coefficient),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_index (out_result_index),
    .out_product_value(out_product_value),
    .out_last_item    (out_last_item),
    .out_error_flag   (out_error_flag)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void push_term(int idx, longint value, bit last, bit err);
    product_term_t term;
    term.idx   = RIDX_W'(idx);
    term.value = value[VAL_W-1:0];
    term.last  = last;
    term.err   = err;
    pending_terms.insert(pending_terms.size(), term);
  endfunction

  function automatic void track_product(logic [CMD_W-1:0] cmd, coef_t coef);
    int     total;
    int     i;
    int     j;
    longint acc;
    case (cmd)
      CMD_APPEND_A: begin
        if (count_a < MAX_TERMS) begin
          terms_a[count_a] = coef;
          count_a++;
        end else begin
          list_overflow = 1'b1;
        end
      end
      CMD_APPEND_B: begin
        if (count_b < MAX_TERMS) begin
          terms_b[count_b] = coef;
          count_b++;
        end else begin
          list_overflow = 1'b1;
        end
      end
      CMD_COMPUTE: begin
        if (count_a == 0 || count_b == 0 || list_overflow) begin
          push_term(0, 0, 1'b1, 1'b1);
        end else begin
          total = count_a + count_b - 1;
          for (i = 0; i < total; i++) begin
            acc = 0;
            for (j = 0; j < count_a; j++) begin
              if (i >= j && i - j < count_b)
                acc += longint'(terms_a[j]) * longint'(terms_b[i - j]);
            end
            push_term(i, acc, i == total - 1, 1'b0);
          end
        end
        count_a = 0;
        count_b = 0;
        list_overflow = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string field, logic signed [63:0] want,
                                        logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // transfer is committed once valid and ready are both high at the falling edge
  always @(negedge clk) begin
    product_term_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_terms.size() == 0) begin
        $error("unexpected result: index %0d value %0d", out_result_index,
               out_product_value);
        fail_count++;
      end else begin
        want = pending_terms.pop_front();
        compare_field("result_index", want.idx, out_result_index);
        compare_field("product_value", want.value, out_product_value);
        compare_field("last_item", want.last, out_last_item);
        compare_field("error_flag", want.err, out_error_flag);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
        out_ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic coef_t random_coef();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0: return COEF_MIN;
      1: return COEF_MAX;
      2: return '0;
      default: return r[COEF_BITS-1:0];
    endcase
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input coef_t coef);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_coefficient <= coef;
    @(negedge clk);
    while (in_ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    track_product(cmd, coef);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic send_run(input int len_a, input int len_b, input bit noisy);
    int left_a;
    int left_b;
    left_a = len_a;
    left_b = len_b;
    while (left_a + left_b > 0) begin
      if (noisy && $urandom_range(0, 15) == 0) send_item(CMD_UNUSED, random_coef());
      if (left_b == 0 || (left_a > 0 && $urandom_range(0, 1) == 0)) begin
        send_item(CMD_APPEND_A, random_coef());
        left_a--;
      end else begin
        send_item(CMD_APPEND_B, random_coef());
        left_b--;
      end
    end
    send_item(CMD_COMPUTE, random_coef());
  endtask

  task automatic test_extreme_values();
    send_item(CMD_APPEND_A, COEF_MIN);
    send_item(CMD_APPEND_A, COEF_MAX);
    send_item(CMD_APPEND_B, COEF_MIN);
    send_item(CMD_APPEND_B, COEF_MAX);
    send_item(CMD_APPEND_B, COEF_MIN);
    send_item(CMD_COMPUTE, COEF_MAX);
  endtask

  task automatic test_single_terms();
    send_item(CMD_APPEND_B, COEF_MAX);
    send_item(CMD_APPEND_A, coef_t'(-1));
    send_item(CMD_COMPUTE, '0);
  endtask

  task automatic test_empty_lists();
    send_item(CMD_COMPUTE, COEF_MIN);
    send_item(CMD_APPEND_A, coef_t'(5));
    send_item(CMD_COMPUTE, '0);
    send_item(CMD_APPEND_B, coef_t'(-7));
    send_item(CMD_COMPUTE, '0);
  endtask

  task automatic test_unused_command();
    send_item(CMD_UNUSED, COEF_MAX);
    send_item(CMD_APPEND_A, coef_t'(3));
    send_item(CMD_UNUSED, COEF_MIN);
    send_item(CMD_APPEND_B, coef_t'(-2));
    send_item(CMD_COMPUTE, '0);
  endtask

  task automatic test_list_overflow();
    send_run(MAX_TERMS + 1, 1, 1'b0);
    send_run(2, MAX_TERMS + 1, 1'b0);
  endtask

  // long sink stall with the widest run in flight; sender keeps offering items
  task automatic test_output_backpressure();
    int k;
    sink_hold_cycles = 300;
    for (k = 0; k < MAX_TERMS; k++) begin
      send_item(CMD_APPEND_A, COEF_MIN);
      send_item(CMD_APPEND_B, COEF_MIN);
    end
    send_item(CMD_COMPUTE, '0);
    send_run(3, 4, 1'b0);
    send_run(2, 2, 1'b0);
  endtask

  task automatic test_drain_pause();
    send_run(4, 5, 1'b0);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_terms.size() != 0);
    send_run(1, 3, 1'b0);
  endtask

  task automatic test_random_runs();
    int stop_at;
    int len_a;
    int len_b;
    stop_at = items_sent + 30;
    while (items_sent < stop_at) begin
      len_a = $urandom_range(1, 8);
      len_b = $urandom_range(1, 8);
      case ($urandom_range(0, 24))
        0: len_a = 0;
        1: len_b = 0;
        2: len_a = MAX_TERMS + $urandom_range(1, 2);
        3: len_b = MAX_TERMS + $urandom_range(1, 2);
        4: begin
          len_a = MAX_TERMS;
          len_b = $urandom_range(1, MAX_TERMS);
        end
        default: ;
      endcase
      send_run(len_a, len_b, 1'b1);
    end
  endtask

  task automatic test_full_speed();
    int k;
    for (k = 0; k < 6; k++) send_run($urandom_range(1, 6), $urandom_range(1, 6), 1'b0);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_APPEND_A;
    in_coefficient = '0;
    src_idle_en    = 1'b1;
    sink_idle_en   = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extreme_values();
    test_single_terms();
    test_empty_lists();
    test_unused_command();
    test_list_overflow();
    test_output_backpressure();
    test_drain_pause();
    test_random_runs();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_full_speed();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_terms.size() != 0);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending_terms.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ipm_pkg.sv
rtl/ipm_cell.sv
rtl/integer_polynomial_multiply_top.sv
test/tb_top.sv
